// ===== src/stqw_pkg.sv =====
package stqw_pkg;

  // configuration port geometry
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_NEUTRAL   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN       = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_LOW  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN_HIGH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STEP      = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEAD      = 3'd5;

  // field widths
  localparam int LEVEL_BITS    = 12;
  localparam int GAIN_BITS     = 16;
  localparam int STEP_BITS     = 13;
  localparam int VALUE_BITS    = 16;
  localparam int RESIDUE_BITS  = 14;
  localparam int SUM_BITS      = 18;  // residue plus value change, signed
  localparam int MAG_BITS      = 17;  // magnitude of that sum
  localparam int DIV_BITS      = 14;  // divisor and remainder of the step divider

  // constants
  localparam logic [DIV_BITS-1:0]   GAIN_ONE        = 14'd10000;
  // reciprocal of the gain unit, exact floor divide for any 32-bit product
  localparam logic [31:0]           GAIN_RECIP      = 32'hD1B71759;
  localparam int                    GAIN_SHIFT      = 45;
  localparam logic [7:0]            RING_RESET      = 8'h66;
  localparam logic [LEVEL_BITS-1:0] NEUTRAL_RESET   = 12'd2048;
  localparam logic [LEVEL_BITS-1:0] MIN_RESET       = 12'd0;
  localparam logic [GAIN_BITS-1:0]  GAIN_RESET      = 16'd10000;
  localparam logic [STEP_BITS-1:0]  STEP_RESET      = 13'd22;
  localparam logic [LEVEL_BITS-1:0] DEAD_RESET      = 12'd250;

  // controller to datapath commands
  typedef struct packed {
    logic take_sample;
    logic mul;
    logic recip;
    logic eval;
    logic kdiv_start;
    logic commit;
  } stqw_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_idle;
    logic big;
  } stqw_stat_t;

endpackage

// ===== src/stqw_div.sv =====
module stqw_div
  import stqw_pkg::*;
#(
  parameter int DW = 17,
  parameter int CW = $clog2(DW + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CW-1:0]       iters,
  input  logic [DW-1:0]       dividend,
  input  logic [DIV_BITS-1:0] divisor,
  output logic                idle,
  output logic [DW-1:0]       quotient,
  output logic [DIV_BITS-1:0] remainder
);

  logic [CW-1:0]       count;
  logic [DIV_BITS-1:0] rem;
  logic [DW-1:0]       sh;
  logic [DIV_BITS-1:0] dvs;
  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   diff;
  logic                ge;
  logic [DIV_BITS-1:0] rem_next;

  // one restoring step: shift in a dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem, sh[DW-1]};
    diff     = trial - {1'b0, dvs};
    ge       = (trial >= {1'b0, dvs});
    rem_next = ge ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
  end

  // iteration counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= iters;
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  // remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      sh  <= dividend;
      dvs <= divisor;
    end else if (count != '0) begin
      rem <= rem_next;
      sh  <= {sh[DW-2:0], ge};
    end
  end

  assign idle      = (count == '0);
  assign quotient  = sh;
  assign remainder = rem;

endmodule

// ===== src/stqw_dp.sv =====
module stqw_dp
  import stqw_pkg::*;
#(
  parameter int SAMPLE_BITS  = 12,
  parameter int CENTRE_VALUE = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  stqw_cmd_t                 cmd,
  output stqw_stat_t                stat,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic [7:0]                wheel,
  output logic signed [15:0]        position,
  output logic signed [15:0]        recentre_moves,
  output logic signed [15:0]        step_moves,
  output logic [VALUE_BITS-1:0]     scaled_value,
  output logic                      in_dead_zone
);

  localparam int RW = (SAMPLE_BITS > LEVEL_BITS) ? SAMPLE_BITS : LEVEL_BITS;
  localparam int PW = RW + GAIN_BITS;
  localparam int DW = MAG_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [VALUE_BITS-1:0] CENTRE16 = VALUE_BITS'(CENTRE_VALUE);

  // configuration registers
  logic [LEVEL_BITS-1:0] neutral_level;
  logic [LEVEL_BITS-1:0] min_level;
  logic [GAIN_BITS-1:0]  gain_low;
  logic [GAIN_BITS-1:0]  gain_high;
  logic [STEP_BITS-1:0]  step_scale;
  logic [LEVEL_BITS-1:0] dead_zone;

  // wheel state
  logic [7:0]                     ring;
  logic [VALUE_BITS-1:0]          prev_value;
  logic signed [RESIDUE_BITS-1:0] step_residue;
  logic signed [15:0]             net_position;

  // per-word working registers
  logic [RW-1:0]              raw;
  logic [PW-1:0]              product;
  logic                       add_centre;
  logic [VALUE_BITS-1:0]      quot;
  logic [VALUE_BITS-1:0]      scaled;
  logic                       in_zone;
  logic signed [SUM_BITS-1:0] sum;
  logic                       big;
  logic                       neg;
  logic [MAG_BITS-1:0]        excess;

  // divider hookup
  logic                div_start;
  logic [CW-1:0]       div_iters;
  logic [DW-1:0]       div_dividend;
  logic [DIV_BITS-1:0] div_divisor;
  logic                div_idle;
  logic [DW-1:0]       div_quotient;
  logic [DIV_BITS-1:0] div_remainder;

  // combinational helpers
  logic [RW-1:0]              nl;
  logic [RW-1:0]              ml;
  logic [RW-1:0]              r_cl;
  logic                       lower;
  logic [RW-1:0]              delta;
  logic [GAIN_BITS-1:0]       gain;
  logic [63:0]                recip_full;
  logic [VALUE_BITS-1:0]      v16;
  logic signed [SUM_BITS-1:0] v_ext;
  logic signed [SUM_BITS-1:0] p_ext;
  logic signed [SUM_BITS-1:0] r_ext;
  logic signed [SUM_BITS-1:0] s_ext;
  logic signed [SUM_BITS-1:0] lo_bound;
  logic signed [SUM_BITS-1:0] hi_bound;
  logic signed [SUM_BITS-1:0] sum_c;
  logic signed [SUM_BITS-1:0] mag_c;
  logic signed [SUM_BITS-1:0] excess_c;
  logic                       inside_c;
  logic                       pos_big;
  logic                       neg_big;
  logic [VALUE_BITS-1:0]      prev_eff;
  logic [STEP_BITS-1:0]       s_eff;
  logic [15:0]                k16;
  logic [15:0]                moves16;
  logic [15:0]                recentre16;
  logic [15:0]                base_pos;
  logic [15:0]                pos_new;
  logic [RESIDUE_BITS-1:0]    residue_new;
  logic [2:0]                 rot;
  logic [15:0]                ring2;
  logic [7:0]                 ring_new;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      neutral_level <= NEUTRAL_RESET;
      min_level     <= MIN_RESET;
      gain_low      <= GAIN_RESET;
      gain_high     <= GAIN_RESET;
      step_scale    <= STEP_RESET;
      dead_zone     <= DEAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NEUTRAL:   neutral_level <= cfg_data[LEVEL_BITS-1:0];
        REG_MIN:       min_level     <= cfg_data[LEVEL_BITS-1:0];
        REG_GAIN_LOW:  gain_low      <= cfg_data[GAIN_BITS-1:0];
        REG_GAIN_HIGH: gain_high     <= cfg_data[GAIN_BITS-1:0];
        REG_STEP:      step_scale    <= cfg_data[STEP_BITS-1:0];
        REG_DEAD:      dead_zone     <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // piecewise selection: clamp low samples, pick offset and gain
  always_comb begin
    nl    = RW'(neutral_level);
    ml    = RW'(min_level);
    r_cl  = ((raw < nl) && (raw < ml)) ? ml : raw;
    lower = (r_cl < nl);
    delta = lower ? (r_cl - ml) : (r_cl - nl);
    gain  = lower ? gain_low : gain_high;
  end

  // divide by the gain unit as a reciprocal multiply
  always_comb begin
    recip_full = 64'(product) * 64'(GAIN_RECIP);
  end

  // dead zone test and residue update
  always_comb begin
    v16      = quot + (add_centre ? CENTRE16 : '0);
    v_ext    = {2'b00, v16};
    lo_bound = $signed(SUM_BITS'(CENTRE_VALUE)) - $signed({6'b0, dead_zone});
    hi_bound = $signed(SUM_BITS'(CENTRE_VALUE)) + $signed({6'b0, dead_zone});
    inside_c = (v_ext > lo_bound) && (v_ext < hi_bound);
    prev_eff = inside_c ? v16 : prev_value;
    p_ext    = {2'b00, prev_eff};
    r_ext    = {{(SUM_BITS - RESIDUE_BITS){step_residue[RESIDUE_BITS-1]}}, step_residue};
    sum_c    = r_ext + v_ext - p_ext;
    s_eff    = (step_scale == '0) ? STEP_BITS'(1) : step_scale;
    s_ext    = {{(SUM_BITS - STEP_BITS){1'b0}}, s_eff};
    pos_big  = (sum_c > s_ext);
    neg_big  = (sum_c < -s_ext);
    mag_c    = neg_big ? -sum_c : sum_c;
    excess_c = mag_c - s_ext - SUM_BITS'(1);
  end

  // divider operands: step count divide
  assign div_start    = cmd.kdiv_start;
  assign div_iters    = CW'(MAG_BITS);
  assign div_dividend = excess;
  assign div_divisor  = {1'b0, s_eff};

  stqw_div #(
    .DW (DW),
    .CW (CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .iters     (div_iters),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .idle      (div_idle),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  // final moves, residue, position and ring rotation
  always_comb begin
    k16         = div_quotient[15:0] + 16'd1;
    moves16     = !big ? 16'd0 : (neg ? -k16 : k16);
    if (!big) begin
      residue_new = sum[RESIDUE_BITS-1:0];
    end else if (neg) begin
      // minus one minus the remainder
      residue_new = ~div_remainder;
    end else begin
      residue_new = div_remainder + RESIDUE_BITS'(1);
    end
    recentre16  = in_zone ? -net_position : 16'd0;
    base_pos    = in_zone ? 16'd0 : net_position;
    pos_new     = base_pos + moves16;
    rot         = recentre16[2:0] + moves16[2:0];
    ring2       = {ring, ring} >> rot;
    ring_new    = ring2[7:0];
  end

  // per-word registers
  always_ff @(posedge clk) begin
    if (cmd.take_sample) begin
      raw <= RW'(sample);
    end
    if (cmd.mul) begin
      product    <= PW'(delta) * PW'(gain);
      add_centre <= !lower;
    end
    if (cmd.recip) begin
      quot <= recip_full[GAIN_SHIFT +: VALUE_BITS];
    end
    if (cmd.eval) begin
      scaled  <= v16;
      in_zone <= inside_c;
      sum     <= sum_c;
      big     <= pos_big | neg_big;
      neg     <= neg_big;
      excess  <= excess_c[MAG_BITS-1:0];
    end
  end

  // wheel state
  always_ff @(posedge clk) begin
    if (rst) begin
      ring         <= RING_RESET;
      prev_value   <= CENTRE16;
      step_residue <= '0;
      net_position <= '0;
    end else if (cmd.commit) begin
      ring         <= ring_new;
      prev_value   <= scaled;
      step_residue <= residue_new;
      net_position <= pos_new;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      wheel          <= ring_new;
      position       <= pos_new;
      recentre_moves <= recentre16;
      step_moves     <= moves16;
      scaled_value   <= scaled;
      in_dead_zone   <= in_zone;
    end
  end

  assign stat.div_idle = div_idle;
  assign stat.big      = big;

endmodule

// ===== src/stqw_ctrl.sv =====
module stqw_ctrl
  import stqw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output stqw_cmd_t  cmd,
  input  stqw_stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_RECIP = 7'b0000100,
    S_EVAL  = 7'b0001000,
    S_STEP  = 7'b0010000,
    S_KDIV  = 7'b0100000,
    S_DONE  = 7'b1000000
  } stqw_state_t;

  stqw_state_t state;
  stqw_state_t state_next;
  logic        out_free;

  assign out_free = !out_valid || !out_stall;

  // sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_sample = 1'b1;
          state_next      = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_RECIP;
      end
      S_RECIP: begin
        cmd.recip  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        if (stat.big) begin
          cmd.kdiv_start = 1'b1;
          state_next     = S_KDIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_KDIV: begin
        if (stat.div_idle) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall = (state != S_IDLE);

`ifndef SYNTHESIS
  // accepted word starts the multiply next cycle
  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_MUL))
    else $error("accepted word did not start the multiply");

  // a new result only appears after the commit state
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("output valid rose outside commit");

  // reciprocal multiply always moves on to evaluation
  a_recip_to_eval: assert property (@(posedge clk) disable iff (rst)
    (state == S_RECIP) |=> (state == S_EVAL))
    else $error("reciprocal multiply did not move to evaluation");

  // blocked output slot holds the finished word back
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("word committed over a pending result");
`endif

endmodule

// ===== src/stick_to_quadrature_wheel.sv =====
// stick to quadrature wheel
//
// input channel: in_valid / in_stall with one raw stick sample per word; a
// word is taken at a clock edge with in_valid high and in_stall low.
// output channel: out_valid / out_stall with one result word per sample:
// wheel byte, net position, recentre and step move counts, scaled value and
// the dead zone flag. the result is held in an output register.
// configuration: cfg_write, cfg_index, cfg_data write one register per edge;
// write only while no sample is in flight.
// sequencing: the gain multiply, then the divide by the gain unit (a
// reciprocal multiply), then the evaluation; a step count divide on a 17
// step serial divider follows only when the motion exceeds one step, and
// only one sample is worked on at a time.
// stall: a finished word waits in the commit state while the previous
// result is stalled at the output; in_stall stays high until it commits.
// reset: synchronous, clears the wheel state (ring 0x66, position and
// residue zero, previous value at centre) and restores register defaults.
module stick_to_quadrature_wheel
  import stqw_pkg::*;
#(
  parameter int SAMPLE_BITS  = 12,
  parameter int CENTRE_VALUE = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [SAMPLE_BITS-1:0]    sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                wheel,
  output logic signed [15:0]        position,
  output logic signed [15:0]        recentre_moves,
  output logic signed [15:0]        step_moves,
  output logic [VALUE_BITS-1:0]     scaled_value,
  output logic                      in_dead_zone,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  stqw_cmd_t  cmd;
  stqw_stat_t stat;

  stqw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  stqw_dp #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .CENTRE_VALUE (CENTRE_VALUE)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .wheel          (wheel),
    .position       (position),
    .recentre_moves (recentre_moves),
    .step_moves     (step_moves),
    .scaled_value   (scaled_value),
    .in_dead_zone   (in_dead_zone)
  );

endmodule

// ===== tb/sv/stick_to_quadrature_wheel_tb.sv =====
`timescale 1ns / 1ps

module stick_to_quadrature_wheel_tb;
  import stqw_pkg::*;

  localparam int SAMPLE_W      = 12;
  localparam int CENTRE        = 2048;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int REPORT_MAX    = 10;
  localparam int CONFIG_SPAN   = 64;
  localparam int RANDOM_WORDS  = 380;

  typedef struct packed {
    logic [7:0]         wheel_byte;
    logic signed [15:0] places;
    logic signed [15:0] recentre;
    logic signed [15:0] steps;
    logic [15:0]        value;
    logic               dead;
  } wheel_word_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [SAMPLE_W-1:0]       sample    = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [7:0]                wheel;
  logic signed [15:0]        position;
  logic signed [15:0]        recentre_moves;
  logic signed [15:0]        step_moves;
  logic [VALUE_BITS-1:0]     scaled_value;
  logic                      in_dead_zone;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // calibration copy, follows every register write
  logic [LEVEL_BITS-1:0] cal_neutral   = NEUTRAL_RESET;
  logic [LEVEL_BITS-1:0] cal_min       = MIN_RESET;
  logic [GAIN_BITS-1:0]  cal_gain_low  = GAIN_RESET;
  logic [GAIN_BITS-1:0]  cal_gain_high = GAIN_RESET;
  logic [STEP_BITS-1:0]  cal_step      = STEP_RESET;
  logic [LEVEL_BITS-1:0] cal_dead      = DEAD_RESET;

  // wheel state as the block should hold it
  logic [7:0]         ring       = RING_RESET;
  logic [15:0]        last_value = 16'(CENTRE);
  int                 residue    = 0;
  logic signed [15:0] net_places = '0;

  wheel_word_t expected_words[$];
  wheel_word_t want_word;
  wheel_word_t got_word;
  int          mismatches     = 0;
  int          quiet_cycles   = 0;
  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;

  stick_to_quadrature_wheel #(
    .SAMPLE_BITS(SAMPLE_W),
    .CENTRE_VALUE(CENTRE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .wheel(wheel),
    .position(position),
    .recentre_moves(recentre_moves),
    .step_moves(step_moves),
    .scaled_value(scaled_value),
    .in_dead_zone(in_dead_zone),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // scale one sample, update the wheel state and return the expected word
  function automatic wheel_word_t predict_wheel(input logic [SAMPLE_W-1:0] raw);
    int unsigned r;
    int unsigned v;
    int          sv;
    int          pos;
    int          s;
    int          recentre;
    int          moves;
    int          res;
    int          k;
    int          turn;
    logic        in_zone;
    logic [15:0] twin;
    wheel_word_t w;
    r = 32'(raw);
    v = 0;
    // piecewise scaling around neutral, low samples clamp to min first
    if (r < cal_neutral) begin
      if (r < cal_min) r = 32'(cal_min);
      v = ((r - cal_min) * cal_gain_low) / GAIN_ONE;
    end
    if (r == cal_neutral) v = CENTRE;
    if (r > cal_neutral) v = ((r - cal_neutral) * cal_gain_high) / GAIN_ONE + CENTRE;
    v = v & 32'hFFFF;
    sv = int'(v);
    pos = net_places;
    s = (cal_step == 0) ? 1 : int'(cal_step);
    recentre = 0;
    moves = 0;
    in_zone = (sv > CENTRE - int'(cal_dead)) && (sv < CENTRE + int'(cal_dead));
    // dead zone turns the wheel back home and cancels this motion
    if (in_zone) begin
      last_value = v[15:0];
      recentre = -pos;
      pos = 0;
    end
    res = residue + (sv - int'(last_value));
    last_value = v[15:0];
    // whole steps of residue turn the wheel
    if (res < -s) begin
      k = (-res - s - 1) / s + 1;
      res += k * s;
      moves = -k;
    end else if (res > s) begin
      k = (res - s - 1) / s + 1;
      res -= k * s;
      moves = k;
    end
    residue = res;
    net_places = 16'(pos + moves);
    turn = recentre + moves;
    twin = {ring, ring} >> turn[2:0];
    ring = twin[7:0];
    w.wheel_byte = ring;
    w.places = net_places;
    w.recentre = recentre[15:0];
    w.steps = moves[15:0];
    w.value = v[15:0];
    w.dead = in_zone;
    return w;
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  // result side stalls at random, changes at the falling edge
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      got_word = {wheel, position, recentre_moves, step_moves, scaled_value, in_dead_zone};
      if (expected_words.size() == 0) begin
        note_mismatch($sformatf("result word with nothing expected, wheel %02h value %0d",
                                wheel, scaled_value));
      end else begin
        want_word = expected_words.pop_front();
        if (got_word.wheel_byte !== want_word.wheel_byte || got_word.places !== want_word.places ||
            got_word.recentre !== want_word.recentre || got_word.steps !== want_word.steps ||
            got_word.value !== want_word.value || got_word.dead !== want_word.dead) begin
          note_mismatch($sformatf(
            "expected wheel %02h pos %0d rec %0d step %0d value %0d dz %0b, got %02h %0d %0d %0d %0d %0b",
            want_word.wheel_byte, want_word.places, want_word.recentre, want_word.steps,
            want_word.value, want_word.dead, got_word.wheel_byte, got_word.places,
            got_word.recentre, got_word.steps, got_word.value, got_word.dead));
        end
      end
    end
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // offer one sample word, with random gaps ahead of it
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    sample = value;
    do @(posedge clk); while (in_stall);
    expected_words.push_back(predict_wheel(value));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                         input logic [CFG_DATA_BITS-1:0] data);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    case (idx)
      REG_NEUTRAL:   cal_neutral = data[LEVEL_BITS-1:0];
      REG_MIN:       cal_min = data[LEVEL_BITS-1:0];
      REG_GAIN_LOW:  cal_gain_low = data[GAIN_BITS-1:0];
      REG_GAIN_HIGH: cal_gain_high = data[GAIN_BITS-1:0];
      REG_STEP:      cal_step = data[STEP_BITS-1:0];
      REG_DEAD:      cal_dead = data[LEVEL_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  // full calibration write, only once every word is back
  task automatic configure(input int neutral, input int min_lvl, input int gain_lo,
                           input int gain_hi, input int step, input int dead);
    wait_idle();
    set_reg(REG_NEUTRAL, CFG_DATA_BITS'(neutral));
    set_reg(REG_MIN, CFG_DATA_BITS'(min_lvl));
    set_reg(REG_GAIN_LOW, CFG_DATA_BITS'(gain_lo));
    set_reg(REG_GAIN_HIGH, CFG_DATA_BITS'(gain_hi));
    set_reg(REG_STEP, CFG_DATA_BITS'(step));
    set_reg(REG_DEAD, CFG_DATA_BITS'(dead));
  endtask

  function automatic int pick(input int lo, input int hi, input int usual);
    case ($urandom_range(5))
      0: return lo;
      1: return hi;
      2: return usual;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic randomize_config();
    int neutral;
    int min_lvl;
    int step;
    neutral = pick(0, 4095, 2048);
    min_lvl = ($urandom_range(3) == 0) ? pick(0, 4095, 0) : $urandom_range(neutral, 0);
    case ($urandom_range(5))
      0: step = 1;
      1: step = 4096;
      2: step = 22;
      3: step = 0;
      default: step = $urandom_range(64, 1);
    endcase
    configure(neutral, min_lvl, pick(0, 65535, 10000), pick(0, 65535, 10000), step,
              pick(0, 2048, 250));
  endtask

  // mostly small walks so the residue and dead zone get exercised
  function automatic logic [SAMPLE_W-1:0] next_sample(input logic [SAMPLE_W-1:0] last);
    int d;
    case ($urandom_range(9))
      0, 1: d = $urandom_range(4095);
      2: d = $urandom_range(1) ? 4095 : 0;
      3, 4: d = int'(cal_neutral) + int'($urandom_range(40)) - 20;
      default: d = int'(last) + int'($urandom_range(128)) - 64;
    endcase
    if (d < 0) d = 0;
    if (d > 4095) d = 4095;
    return d[SAMPLE_W-1:0];
  endfunction

  // reset calibration: neutral, extremes, return into the dead zone
  task automatic test_reset_defaults();
    send_sample(12'd2048);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd2047);
    send_sample(12'd2049);
    send_sample(12'd2048);
  endtask

  // min above neutral, zero step scale, no dead zone
  task automatic test_clamp_above_neutral();
    configure(1000, 3000, 10000, 10000, 0, 0);
    send_sample(12'd0);
    send_sample(12'd3500);
    send_sample(12'd1000);
    send_sample(12'd500);
  endtask

  // min equal to neutral, zero high gain, widest dead zone, largest step
  task automatic test_flat_gains();
    configure(1500, 1500, 65535, 0, 4096, 2048);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd1400);
    send_sample(12'd1499);
  endtask

  // full scale swings at one unit per step, then a long recentre
  task automatic test_full_travel();
    configure(0, 0, 10000, 65535, 1, 0);
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
    configure(4095, 0, 65535, 10000, 1, 0);
    send_sample(12'd0);
    send_sample(12'd4094);
    send_sample(12'd4095);
    send_sample(12'd0);
    configure(4095, 0, 65535, 10000, 1, 2048);
    send_sample(12'd4095);
  endtask

  // random traffic under fresh calibrations, with full drains now and then
  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int words);
    int          sent;
    logic [SAMPLE_W-1:0] last;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    last = SAMPLE_W'(CENTRE);
    while (sent < words) begin
      if (sent % CONFIG_SPAN == 0) randomize_config();
      else if ($urandom_range(49) == 0) wait_idle();
      last = next_sample(last);
      send_sample(last);
      sent++;
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_clamp_above_neutral();
    test_flat_gains();
    test_full_travel();
    test_random_traffic(28, 65, RANDOM_WORDS);
    test_random_traffic(65, 28, RANDOM_WORDS);
    test_random_traffic(0, 0, RANDOM_WORDS);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
